### rtl/focus_phase_generator_assert.svh
// ----------------------------------------------------------------------------
// Focus phase generator assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FOCUS_PHASE_GENERATOR_ASSERT_SVH
`define FOCUS_PHASE_GENERATOR_ASSERT_SVH

// same-cycle implication
`define FPG_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("focus_phase_generator: check failed");

// next-cycle implication
`define FPG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("focus_phase_generator: check failed");

`endif

### rtl/fpg_pkg.sv
// ----------------------------------------------------------------------------
// Focus phase generator package
// Widths, reset values, register indexes and inter-stage word types.
// ----------------------------------------------------------------------------
package fpg_pkg;

    localparam int COORD_W     = 20;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int SQ_W        = 2 * COORD_W + 1;
    localparam int SUM_W       = SQ_W + 1;
    localparam int FRAC_SHIFT  = 8;
    localparam int RAD_W       = SUM_W + FRAC_SHIFT;
    localparam int DIST_W      = RAD_W / 2;
    localparam int REM_W       = DIST_W + 1;
    localparam int WAVE_W      = 32;
    localparam int PHASE_W     = 16;
    localparam int PHASE_SHIFT = 28;
    localparam int PROD_W      = PHASE_SHIFT + PHASE_W;
    localparam int CFG_W       = 32;
    localparam int CFG_ADDR_W  = 2;

    localparam logic [WAVE_W-1:0] WAVE_RESET = 32'd128222930;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FOCUS_X     = 2'd0,
        REG_FOCUS_Y     = 2'd1,
        REG_FOCUS_Z     = 2'd2,
        REG_WAVE_NUMBER = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] sum;
    } sum_word_t;

    typedef struct packed {
        logic              valid;
        logic [DIST_W-1:0] radius;
    } dist_word_t;

    typedef struct packed {
        logic               valid;
        logic [PHASE_W-1:0] phase;
    } phase_word_t;

endpackage

### rtl/fpg_diff_sq.sv
// ----------------------------------------------------------------------------
// Focus phase generator: squared distance
// Three stages: coordinate differences, squares, sum of squares.
// ----------------------------------------------------------------------------
module fpg_diff_sq (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  logic                                in_valid,
    input  logic signed [fpg_pkg::COORD_W-1:0]  elem_x,
    input  logic signed [fpg_pkg::COORD_W-1:0]  elem_y,
    input  logic signed [fpg_pkg::COORD_W-1:0]  elem_z,
    input  logic signed [fpg_pkg::COORD_W-1:0]  focus_x,
    input  logic signed [fpg_pkg::COORD_W-1:0]  focus_y,
    input  logic signed [fpg_pkg::COORD_W-1:0]  focus_z,
    output fpg_pkg::sum_word_t                  sum_word
);

    logic                                 diff_v_reg;
    logic signed [fpg_pkg::DIFF_W-1:0]    dx_reg, dy_reg, dz_reg;
    logic signed [fpg_pkg::DIFF_W-1:0]    dx_next, dy_next, dz_next;

    logic                                 sq_v_reg;
    logic [fpg_pkg::SQ_W-1:0]             sqx_reg, sqy_reg, sqz_reg;
    logic signed [2*fpg_pkg::DIFF_W-1:0]  prod_x, prod_y, prod_z;

    logic                                 sum_v_reg;
    logic [fpg_pkg::SUM_W-1:0]            sum_reg;
    logic [fpg_pkg::SUM_W-1:0]            sum_next;

    // differences are exact in one extra bit
    assign dx_next = {focus_x[fpg_pkg::COORD_W-1], focus_x}
                   - {elem_x[fpg_pkg::COORD_W-1], elem_x};
    assign dy_next = {focus_y[fpg_pkg::COORD_W-1], focus_y}
                   - {elem_y[fpg_pkg::COORD_W-1], elem_y};
    assign dz_next = {focus_z[fpg_pkg::COORD_W-1], focus_z}
                   - {elem_z[fpg_pkg::COORD_W-1], elem_z};

    assign prod_x = dx_reg * dx_reg;
    assign prod_y = dy_reg * dy_reg;
    assign prod_z = dz_reg * dz_reg;

    assign sum_next = {1'b0, sqx_reg} + {1'b0, sqy_reg} + {1'b0, sqz_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_v_reg <= 1'b0;
            sq_v_reg   <= 1'b0;
            sum_v_reg  <= 1'b0;
        end
        else if (adv)
        begin
            diff_v_reg <= in_valid;
            sq_v_reg   <= diff_v_reg;
            sum_v_reg  <= sq_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
            dz_reg  <= dz_next;
            sqx_reg <= prod_x[fpg_pkg::SQ_W-1:0];
            sqy_reg <= prod_y[fpg_pkg::SQ_W-1:0];
            sqz_reg <= prod_z[fpg_pkg::SQ_W-1:0];
            sum_reg <= sum_next;
        end
    end

    assign sum_word.valid = sum_v_reg;
    assign sum_word.sum   = sum_reg;

endmodule

### rtl/fpg_sqrt.sv
// ----------------------------------------------------------------------------
// Focus phase generator: pipelined square root
// Restoring digit recurrence, one root bit per stage, floor(sqrt(sum * 256)).
// ----------------------------------------------------------------------------
module fpg_sqrt (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  fpg_pkg::sum_word_t   sum_word,
    output fpg_pkg::dist_word_t  dist_word
);

    localparam int N     = fpg_pkg::DIST_W;
    localparam int RAD_W = fpg_pkg::RAD_W;
    localparam int REM_W = fpg_pkg::REM_W;

    logic             v_reg    [N];
    logic [RAD_W-1:0] rad_reg  [N];
    logic [REM_W-1:0] rem_reg  [N];
    logic [N-1:0]     root_reg [N];

    for (genvar k = 0; k < N; k++)
    begin : g_step
        logic             v_in;
        logic [RAD_W-1:0] rad_in;
        logic [REM_W-1:0] rem_in;
        logic [N-1:0]     root_in;
        logic [REM_W+1:0] trial;
        logic [REM_W+1:0] sub;
        logic [REM_W+1:0] diff;
        logic             ge;

        if (k == 0)
        begin : g_first
            assign v_in    = sum_word.valid;
            assign rad_in  = {sum_word.sum, {fpg_pkg::FRAC_SHIFT{1'b0}}};
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign v_in    = v_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        // bring down the next radicand bit pair, try 4*root + 1
        assign trial = {rem_in, rad_in[RAD_W-1 -: 2]};
        assign sub   = {1'b0, root_in, 2'b01};
        assign ge    = (trial >= sub);
        assign diff  = trial - sub;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rad_reg[k]  <= {rad_in[RAD_W-3:0], 2'b00};
                rem_reg[k]  <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
                root_reg[k] <= {root_in[N-2:0], ge};
            end
        end
    end

    // the root never exceeds its 25-bit range, so the clamp is implicit
    assign dist_word.valid  = v_reg[N-1];
    assign dist_word.radius = root_reg[N-1];

endmodule

### rtl/fpg_phase.sv
// ----------------------------------------------------------------------------
// Focus phase generator: phase stage
// Multiply distance by wave number, round to 2^-16 turn and negate.
// ----------------------------------------------------------------------------
module fpg_phase (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  fpg_pkg::dist_word_t          dist_word,
    input  logic [fpg_pkg::WAVE_W-1:0]   wave_number,
    output fpg_pkg::phase_word_t         phase_word
);

    localparam int PW = fpg_pkg::PROD_W;
    localparam int PS = fpg_pkg::PHASE_SHIFT;
    localparam logic [PW-1:0] HALF_LSB = {{(PW-PS){1'b0}}, 1'b1, {(PS-1){1'b0}}};

    logic [fpg_pkg::WAVE_W+fpg_pkg::DIST_W-1:0] prod_full;
    logic                                       prod_v_reg;
    logic [PW-1:0]                              prod_reg;
    logic [PW-1:0]                              rounded;
    logic                                       phase_v_reg;
    logic [fpg_pkg::PHASE_W-1:0]                phase_reg;
    logic [fpg_pkg::PHASE_W-1:0]                phase_next;

    // only the bits below one turn matter after the wrap
    assign prod_full  = wave_number * dist_word.radius;
    assign rounded    = prod_reg + HALF_LSB;
    assign phase_next = '0 - rounded[PW-1 -: fpg_pkg::PHASE_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_v_reg  <= 1'b0;
            phase_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            prod_v_reg  <= dist_word.valid;
            phase_v_reg <= prod_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg  <= prod_full[PW-1:0];
            phase_reg <= phase_next;
        end
    end

    assign phase_word.valid = phase_v_reg;
    assign phase_word.phase = phase_reg;

endmodule

### rtl/fpg_out_buf.sv
// ----------------------------------------------------------------------------
// Focus phase generator: output buffer
// Output register plus skid register; stalls the pipeline only when both
// hold a word and another word waits at the pipeline end.
// ----------------------------------------------------------------------------
module fpg_out_buf (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fpg_pkg::phase_word_t          phase_word,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [fpg_pkg::PHASE_W-1:0]   drive_phase,
    output logic                          adv
);

    logic                        out_v_reg, out_v_next;
    logic [fpg_pkg::PHASE_W-1:0] out_d_reg, out_d_next;
    logic                        skid_v_reg, skid_v_next;
    logic [fpg_pkg::PHASE_W-1:0] skid_d_reg, skid_d_next;
    logic                        push;
    logic                        pop;

    assign adv  = !phase_word.valid || !skid_v_reg;
    assign push = phase_word.valid && adv;
    assign pop  = out_v_reg && out_ready;

    always_comb
    begin
        out_v_next  = out_v_reg;
        out_d_next  = out_d_reg;
        skid_v_next = skid_v_reg;
        skid_d_next = skid_d_reg;
        if (!out_v_reg || pop)
        begin
            if (skid_v_reg)
            begin
                // drain skid first, keep order
                out_v_next  = 1'b1;
                out_d_next  = skid_d_reg;
                skid_v_next = push;
                skid_d_next = phase_word.phase;
            end
            else
            begin
                out_v_next = push;
                out_d_next = phase_word.phase;
            end
        end
        else if (push)
        begin
            skid_v_next = 1'b1;
            skid_d_next = phase_word.phase;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_d_reg  <= out_d_next;
        skid_d_reg <= skid_d_next;
    end

    assign out_valid   = out_v_reg;
    assign drive_phase = out_d_reg;

endmodule

### rtl/focus_phase_generator.sv
// ----------------------------------------------------------------------------
// Focus phase generator
// Path from input acceptance to out_valid: 3 distance stages, 25 square-root
// stages, multiply, round, output register. Throughput: one word per cycle,
// set by the one-bit-per-stage root pipeline, unless the output buffer stalls.
// Reset: asynchronous, clears all valid bits; focus at origin, 40 kHz wave.
// ----------------------------------------------------------------------------
module focus_phase_generator (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [fpg_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [fpg_pkg::CFG_W-1:0]            cfg_wdata,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [fpg_pkg::COORD_W-1:0]   elem_x,
    input  logic signed [fpg_pkg::COORD_W-1:0]   elem_y,
    input  logic signed [fpg_pkg::COORD_W-1:0]   elem_z,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [fpg_pkg::PHASE_W-1:0]          drive_phase
);

    logic signed [fpg_pkg::COORD_W-1:0] focus_x_reg, focus_y_reg, focus_z_reg;
    logic [fpg_pkg::WAVE_W-1:0]         wave_number_reg;

    logic                  adv;
    fpg_pkg::sum_word_t    sum_word;
    fpg_pkg::dist_word_t   dist_word;
    fpg_pkg::phase_word_t  phase_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focus_x_reg     <= '0;
            focus_y_reg     <= '0;
            focus_z_reg     <= '0;
            wave_number_reg <= fpg_pkg::WAVE_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                fpg_pkg::REG_FOCUS_X:
                    focus_x_reg <= cfg_wdata[fpg_pkg::COORD_W-1:0];
                fpg_pkg::REG_FOCUS_Y:
                    focus_y_reg <= cfg_wdata[fpg_pkg::COORD_W-1:0];
                fpg_pkg::REG_FOCUS_Z:
                    focus_z_reg <= cfg_wdata[fpg_pkg::COORD_W-1:0];
                fpg_pkg::REG_WAVE_NUMBER:
                    wave_number_reg <= cfg_wdata[fpg_pkg::WAVE_W-1:0];
                default:
                    ;
            endcase
        end
    end

    assign in_ready = adv;

    fpg_diff_sq u_diff_sq (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (in_valid),
        .elem_x   (elem_x),
        .elem_y   (elem_y),
        .elem_z   (elem_z),
        .focus_x  (focus_x_reg),
        .focus_y  (focus_y_reg),
        .focus_z  (focus_z_reg),
        .sum_word (sum_word)
    );

    fpg_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .sum_word  (sum_word),
        .dist_word (dist_word)
    );

    fpg_phase u_phase (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .dist_word   (dist_word),
        .wave_number (wave_number_reg),
        .phase_word  (phase_word)
    );

    fpg_out_buf u_out_buf (
        .clk         (clk),
        .rst_n       (rst_n),
        .phase_word  (phase_word),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .drive_phase (drive_phase),
        .adv         (adv)
    );

`include "focus_phase_generator_assert.svh"

    // a stall needs a full output side and a word waiting behind it
    `FPG_ASSERT_SAME(a_stall_cause, !in_ready, out_valid && phase_word.valid)
    // one word taken at the output releases the stall
    `FPG_ASSERT_NEXT(a_stall_release, !in_ready && out_ready, in_ready)

endmodule

### verif/focus_phase_checker.sv
// ----------------------------------------------------------------------------
// Focus phase checker
// Watches the register port and both word channels of the focus phase
// generator, predicts the drive phase of every accepted element position and
// compares it with the words that leave the block, oldest first.
// ----------------------------------------------------------------------------
module focus_phase_checker
    import fpg_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [CFG_W-1:0]          cfg_wdata,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic signed [COORD_W-1:0] elem_x,
    input  logic signed [COORD_W-1:0] elem_y,
    input  logic signed [COORD_W-1:0] elem_z,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic [PHASE_W-1:0]        drive_phase,
    output int unsigned               phase_errors,
    output int unsigned               phases_in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [COORD_W-1:0] focus_x;
    logic signed [COORD_W-1:0] focus_y;
    logic signed [COORD_W-1:0] focus_z;
    logic [WAVE_W-1:0]         wave_number;
    logic [PHASE_W-1:0]        expected_phases[$];

    function automatic logic [PHASE_W-1:0] focus_phase(logic signed [COORD_W-1:0] ex,
                                                       logic signed [COORD_W-1:0] ey,
                                                       logic signed [COORD_W-1:0] ez);
        longint      dx;
        longint      dy;
        longint      dz;
        logic [63:0] radicand;
        logic [63:0] radius;
        logic [63:0] trial;
        logic [63:0] product;
        logic [63:0] turns;
        dx = longint'(focus_x) - longint'(ex);
        dy = longint'(focus_y) - longint'(ey);
        dz = longint'(focus_z) - longint'(ez);
        radicand = 64'(dx * dx + dy * dy + dz * dz) << FRAC_SHIFT;
        // one root bit per step; limiting to DIST_W bits also gives the clamp
        radius = '0;
        for (int b = DIST_W - 1; b >= 0; b--) begin
            trial = radius | (64'd1 << b);
            if (trial * trial <= radicand)
                radius = trial;
        end
        product = radius * 64'(wave_number);
        turns = (product + (64'd1 << (PHASE_SHIFT - 1))) >> PHASE_SHIFT;
        return PHASE_W'(64'd0 - turns);
    endfunction

    always @(posedge clk or negedge rst_n) begin
        logic [PHASE_W-1:0] expected;
        if (!rst_n) begin
            focus_x = '0;
            focus_y = '0;
            focus_z = '0;
            wave_number = WAVE_RESET;
            expected_phases.delete();
            phase_errors <= 0;
            phases_in_flight <= 0;
        end
        else begin
            // check the outgoing word before queueing a new one
            if (out_valid && out_ready) begin
                if (expected_phases.size() == 0) begin
                    $display("%0t: drive_phase expected none actual %h", $time, drive_phase);
                    phase_errors <= phase_errors + 1;
                end
                else begin
                    expected = expected_phases.pop_front();
                    if (drive_phase !== expected) begin
                        $display("%0t: drive_phase expected %h actual %h",
                                 $time, expected, drive_phase);
                        phase_errors <= phase_errors + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_phases.push_back(focus_phase(elem_x, elem_y, elem_z));
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_addr))
                    REG_FOCUS_X:     focus_x = cfg_wdata[COORD_W-1:0];
                    REG_FOCUS_Y:     focus_y = cfg_wdata[COORD_W-1:0];
                    REG_FOCUS_Z:     focus_z = cfg_wdata[COORD_W-1:0];
                    REG_WAVE_NUMBER: wave_number = cfg_wdata[WAVE_W-1:0];
                    default:         ;
                endcase
            end
            phases_in_flight <= expected_phases.size();
        end
    end

endmodule

### verif/tb_focus_phase_generator.sv
// ----------------------------------------------------------------------------
// Focus phase generator testbench
// Drives element positions through the generator under several focal points
// and wave numbers, with random gaps on both channels and one long output
// stall, and leaves the checking to the focus phase checker.
// ----------------------------------------------------------------------------
module tb_focus_phase_generator import fpg_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned LONG_HOLD     = 300;
    localparam int unsigned RANDOM_PHASES = 8;
    localparam int unsigned PHASE_ITEMS   = 160;
    localparam int unsigned DRAIN_CYCLES  = 40;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_wr_en;
    logic [CFG_ADDR_W-1:0]     cfg_addr;
    logic [CFG_W-1:0]          cfg_wdata;
    logic                      in_valid;
    logic                      in_ready;
    logic signed [COORD_W-1:0] elem_x;
    logic signed [COORD_W-1:0] elem_y;
    logic signed [COORD_W-1:0] elem_z;
    logic                      out_valid;
    logic                      out_ready;
    logic [PHASE_W-1:0]        drive_phase;
    int unsigned               phase_errors;
    int unsigned               phases_in_flight;

    bit                        no_idle;
    bit                        long_hold_req;
    logic signed [COORD_W-1:0] cur_fx;
    logic signed [COORD_W-1:0] cur_fy;
    logic signed [COORD_W-1:0] cur_fz;

    focus_phase_generator uut (.*);

    focus_phase_checker checker_i (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic write_register(cfg_reg_t idx, logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
    endtask

    // upper bits of the focus registers are junk that the block must ignore
    task automatic apply_config(logic signed [COORD_W-1:0] fx,
                                logic signed [COORD_W-1:0] fy,
                                logic signed [COORD_W-1:0] fz,
                                logic [WAVE_W-1:0] wave);
        write_register(REG_FOCUS_X, {(CFG_W-COORD_W)'($urandom), fx});
        write_register(REG_FOCUS_Y, {(CFG_W-COORD_W)'($urandom), fy});
        write_register(REG_FOCUS_Z, {(CFG_W-COORD_W)'($urandom), fz});
        write_register(REG_WAVE_NUMBER, wave);
        cfg_wr_en <= 1'b0;
        cur_fx = fx;
        cur_fy = fy;
        cur_fz = fz;
    endtask

    task automatic send_element(logic signed [COORD_W-1:0] x,
                                logic signed [COORD_W-1:0] y,
                                logic signed [COORD_W-1:0] z);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        elem_x   <= x;
        elem_y   <= y;
        elem_z   <= z;
        do @(posedge clk); while (!(in_valid && in_ready));
    endtask

    // drop valid, then hold until every predicted word has come out
    task automatic wait_pipeline_empty();
        in_valid <= 1'b0;
        @(posedge clk);
        while (phases_in_flight != 0) @(posedge clk);
    endtask

    function automatic logic signed [COORD_W-1:0] edge_coord(logic signed [COORD_W-1:0] f);
        case ($urandom_range(0, 4))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2:       return '0;
            3:       return '1;
            default: return f;
        endcase
    endfunction

    function automatic logic signed [COORD_W-1:0] near_coord(logic signed [COORD_W-1:0] f);
        return COORD_W'(int'(f) + int'($urandom_range(0, 128)) - 64);
    endfunction

    function automatic logic signed [COORD_W-1:0] config_coord();
        case ($urandom_range(0, 4))
            0, 1, 2: return COORD_W'($urandom);
            3:       return ($urandom_range(0, 1) != 0) ? COORD_MAX : COORD_MIN;
            default: return '0;
        endcase
    endfunction

    function automatic logic [WAVE_W-1:0] config_wave();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return WAVE_RESET;
            3:       return WAVE_W'($urandom_range(0, 1 << 20));
            default: return WAVE_W'($urandom);
        endcase
    endfunction

    task automatic send_random_element();
        int unsigned kind;
        kind = $urandom_range(0, 99);
        if (kind < 40)
            send_element(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
        else if (kind < 65)
            send_element(near_coord(cur_fx), near_coord(cur_fy), near_coord(cur_fz));
        else if (kind < 80)
            send_element(edge_coord(cur_fx), edge_coord(cur_fy), edge_coord(cur_fz));
        else
            send_element(COORD_W'(int'($urandom_range(0, 8191)) - 4096),
                         COORD_W'(int'($urandom_range(0, 8191)) - 4096),
                         COORD_W'(int'($urandom_range(0, 8191)) - 4096));
    endtask

    // output side: random hold per word, one long hold on request
    initial
    begin
        int unsigned hold;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD;
            end
            else begin
                hold = no_idle ? 0 : $urandom_range(0, 4);
            end
            if (hold != 0) begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    initial
    begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("focus_phase_generator: mismatch");
        $finish;
    end

    initial
    begin
        rst_n     <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= REG_FOCUS_X;
        cfg_wdata <= '0;
        in_valid  <= 1'b0;
        elem_x    <= '0;
        elem_y    <= '0;
        elem_z    <= '0;
        no_idle = 1'b0;
        long_hold_req = 1'b0;
        cur_fx = '0;
        cur_fy = '0;
        cur_fz = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset focus at the origin, default wave number
        send_element('0, '0, '0);
        send_element(COORD_MAX, '0, '0);
        send_element(COORD_MIN, '0, '0);
        send_element('0, COORD_MAX, '0);
        send_element('0, COORD_MIN, '0);
        send_element('0, '0, COORD_MAX);
        send_element('0, '0, COORD_MIN);
        send_element(COORD_MIN, COORD_MIN, COORD_MIN);
        send_element(COORD_MAX, COORD_MAX, COORD_MAX);
        send_element(20'sd1, '0, '0);
        send_element('1, '1, '1);
        send_element(20'sd3, 20'sd4, '0);
        wait_pipeline_empty();

        // longest distance with the largest wave number
        apply_config(COORD_MAX, COORD_MAX, COORD_MAX, '1);
        send_element(COORD_MIN, COORD_MIN, COORD_MIN);
        send_element(COORD_MAX, COORD_MAX, COORD_MAX);
        send_element(COORD_MAX - 20'sd1, COORD_MAX, COORD_MAX);
        wait_pipeline_empty();

        // zero wave number gives zero phase everywhere
        apply_config(COORD_MIN, COORD_MIN, COORD_MIN, '0);
        send_element(COORD_MAX, COORD_MAX, COORD_MAX);
        send_element('0, '0, '0);
        send_element(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
        wait_pipeline_empty();

        apply_config(COORD_MAX, COORD_MIN, '0, WAVE_W'(1));
        send_element(COORD_MIN, COORD_MAX, '0);
        send_element('0, '0, '0);
        wait_pipeline_empty();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            no_idle = (p % 3 == 1);
            apply_config(config_coord(), config_coord(), config_coord(), config_wave());
            // stall the output long enough to back up the pipeline
            if (p == 4)
                long_hold_req = 1'b1;
            repeat (PHASE_ITEMS) send_random_element();
            wait_pipeline_empty();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (phase_errors == 0)
            $display("focus_phase_generator: match");
        else
            $display("focus_phase_generator: mismatch");
        $finish;
    end

endmodule
